### sv/mis_pkg.sv
// mis_pkg: shared types, constants and lookup functions of the mouse input scanner
// no dependencies

package mis_pkg;

    localparam int PIN_COUNT      = 7;
    localparam int REPORT_BUTTONS = 5;
    localparam int UP_KEY         = 5;
    localparam int DOWN_KEY       = 6;
    localparam int PRESET_W       = 3;
    localparam int RES_W          = 12;
    localparam int MOVE_W         = 16;
    localparam int IDLE_W         = 32;
    localparam int LIMIT_W        = 8;

    localparam logic REG_DEBOUNCE_LIMIT = 1'b0;
    localparam logic REG_SUSPEND_TICKS  = 1'b1;

    localparam logic [LIMIT_W-1:0]  DEBOUNCE_LIMIT_RST = 8'd10;
    localparam logic [IDLE_W-1:0]   SUSPEND_TICKS_RST  = 32'd1000000;
    localparam logic [PRESET_W-1:0] PRESET_RST         = 3'd1;

    localparam logic [1:0] WHEEL_NONE = 2'b00;
    localparam logic [1:0] WHEEL_CW   = 2'b11;
    localparam logic [1:0] WHEEL_CCW  = 2'b01;

    typedef struct packed {
        logic [PIN_COUNT-1:0] pressed;
        logic [PIN_COUNT-1:0] rise;
    } deb_status_t;

    // place of a phase pattern along the clockwise sequence 00,01,11,10
    function automatic logic [1:0] phase_position(input logic [1:0] p);
        logic [1:0] r;
        case (p)
            2'b00:   r = 2'd0;
            2'b01:   r = 2'd1;
            2'b11:   r = 2'd2;
            2'b10:   r = 2'd3;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [RES_W-1:0] resolution_of(input logic [PRESET_W-1:0] idx);
        logic [RES_W-1:0] r;
        case (idx)
            3'd0:    r = 12'd800;
            3'd1:    r = 12'd1200;
            3'd2:    r = 12'd1600;
            3'd3:    r = 12'd2400;
            default: r = 12'd3200;
        endcase
        return r;
    endfunction

endpackage

### sv/mis_debounce.sv
// mis_debounce: saturating press counters and pressed flags for all buttons
// depends on mis_pkg

module mis_debounce (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  logic [mis_pkg::PIN_COUNT-1:0]       pins,
    input  logic [mis_pkg::LIMIT_W-1:0]         limit,
    output mis_pkg::deb_status_t                status
);

    logic [mis_pkg::LIMIT_W-1:0]   count_reg  [mis_pkg::PIN_COUNT];
    logic [mis_pkg::LIMIT_W-1:0]   count_next [mis_pkg::PIN_COUNT];
    logic [mis_pkg::PIN_COUNT-1:0] flag_reg;
    logic [mis_pkg::PIN_COUNT-1:0] flag_next;

    always_comb begin
        for (int i = 0; i < mis_pkg::PIN_COUNT; i++) begin
            if (!pins[i]) begin
                count_next[i] = (count_reg[i] < limit) ? count_reg[i] + 8'd1 : count_reg[i];
                flag_next[i]  = flag_reg[i] | (count_next[i] >= limit);
            end else begin
                count_next[i] = '0;
                flag_next[i]  = 1'b0;
            end
        end
    end

    assign status.pressed = flag_next;
    assign status.rise    = flag_next & ~flag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mis_pkg::PIN_COUNT; i++) begin
                count_reg[i] <= '0;
            end
            flag_reg <= '0;
        end else if (advance) begin
            for (int i = 0; i < mis_pkg::PIN_COUNT; i++) begin
                count_reg[i] <= count_next[i];
            end
            flag_reg <= flag_next;
        end
    end

endmodule

### sv/mouse_input_scanner_unit.sv
// mouse_input_scanner_unit: button debounce, quadrature wheel, preset keys and idle report
// depends on mis_pkg and mis_debounce
//
//   channel   dir   handshake           payload
//   s_        in    s_tvalid/s_tready   s_tdata, s_tuser (one scan tick)
//   m_        out   m_tvalid/m_tready   m_tdata, m_tuser (one report per tick)
//   apb       in    psel/penable        paddr, pwdata, prdata
//
// one item per cycle while m_ is not stalled; a tick's result is registered before m_
// path: input register, debounce/wheel/preset logic, result register
// ticks are processed when the result register is empty or being drained
// a stalled result holds while one more item waits in the input register
// aresetn clears all scan state and loads register reset values

module mouse_input_scanner_unit #(
    parameter int PRESET_COUNT = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [6:0] button_pins, [8:7] wheel_phase, [24:9] move_x, [40:25] move_y
    input  logic [47:0] s_tdata,
    // [0] motion_line
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] report_buttons, [20:5] report_dx, [36:21] report_dy, [38:37] wheel_step,
    // [41:39] preset_index, [53:42] resolution_x, [65:54] resolution_y,
    // [66] preset_changed, [67] suspend_request
    output logic [71:0] m_tdata,
    // [0] report_valid
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [mis_pkg::PRESET_W-1:0] PRESET_TOP = mis_pkg::PRESET_W'(PRESET_COUNT - 1);

    // configuration
    logic [mis_pkg::LIMIT_W-1:0] limit_reg;
    logic [mis_pkg::IDLE_W-1:0]  suspend_ticks_reg;
    logic                        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg         <= mis_pkg::DEBOUNCE_LIMIT_RST;
            suspend_ticks_reg <= mis_pkg::SUSPEND_TICKS_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                mis_pkg::REG_DEBOUNCE_LIMIT: limit_reg         <= pwdata[mis_pkg::LIMIT_W-1:0];
                mis_pkg::REG_SUSPEND_TICKS:  suspend_ticks_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mis_pkg::REG_DEBOUNCE_LIMIT: prdata = {24'd0, limit_reg};
            mis_pkg::REG_SUSPEND_TICKS:  prdata = suspend_ticks_reg;
            default:                     prdata = '0;
        endcase
    end

    // input register
    logic        in_valid_reg;
    logic [40:0] in_data_reg;
    logic        in_motion_reg;
    logic        advance;

    assign advance  = in_valid_reg & (~m_tvalid | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg   <= s_tdata[40:0];
            in_motion_reg <= s_tuser;
        end
    end

    logic [mis_pkg::PIN_COUNT-1:0] pins;
    logic [1:0]                    phase;
    logic [mis_pkg::MOVE_W-1:0]    mx;
    logic [mis_pkg::MOVE_W-1:0]    my;

    assign pins  = in_data_reg[6:0];
    assign phase = in_data_reg[8:7];
    assign mx    = in_data_reg[24:9];
    assign my    = in_data_reg[40:25];

    // scan state
    logic [mis_pkg::REPORT_BUTTONS-1:0] prev_buttons_reg;
    logic [1:0]                         prev_phase_reg;
    logic                               primed_reg;
    logic [mis_pkg::PRESET_W-1:0]       preset_reg;
    logic [mis_pkg::IDLE_W-1:0]         idle_reg;

    mis_pkg::deb_status_t deb;

    mis_debounce u_debounce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .pins    (pins),
        .limit   (limit_reg),
        .status  (deb)
    );

    logic [mis_pkg::MOVE_W-1:0]         dx;
    logic [mis_pkg::MOVE_W-1:0]         dy;
    logic [1:0]                         delta;
    logic [1:0]                         wheel;
    logic [mis_pkg::PRESET_W-1:0]       preset_base;
    logic [mis_pkg::PRESET_W-1:0]       preset_up;
    logic [mis_pkg::PRESET_W-1:0]       preset_next;
    logic                               changed;
    logic [mis_pkg::REPORT_BUTTONS-1:0] buttons;
    logic                               report;
    logic [mis_pkg::IDLE_W-1:0]         idle_next;
    logic                               suspend;

    always_comb begin
        dx = in_motion_reg ? '0 : mx;
        dy = in_motion_reg ? '0 : my;

        delta = mis_pkg::phase_position(phase) - mis_pkg::phase_position(prev_phase_reg);
        wheel = mis_pkg::WHEEL_NONE;
        if (primed_reg) begin
            case (delta)
                2'd1:    wheel = mis_pkg::WHEEL_CW;
                2'd3:    wheel = mis_pkg::WHEEL_CCW;
                default: wheel = mis_pkg::WHEEL_NONE;
            endcase
        end

        preset_base = (preset_reg > PRESET_TOP) ? PRESET_TOP : preset_reg;
        preset_up   = preset_base;
        if (deb.rise[mis_pkg::UP_KEY]) begin
            preset_up = (preset_base < PRESET_TOP) ? preset_base + 3'd1 : '0;
        end
        preset_next = preset_up;
        if (deb.rise[mis_pkg::DOWN_KEY]) begin
            preset_next = (preset_up != '0) ? preset_up - 3'd1 : PRESET_TOP;
        end
        changed = deb.rise[mis_pkg::UP_KEY] | deb.rise[mis_pkg::DOWN_KEY];

        buttons = deb.pressed[mis_pkg::REPORT_BUTTONS-1:0];
        report  = (wheel != mis_pkg::WHEEL_NONE) | (buttons != prev_buttons_reg)
                | (dx != '0) | (dy != '0);

        if (report) begin
            idle_next = '0;
        end else if (idle_reg != '1) begin
            idle_next = idle_reg + 32'd1;
        end else begin
            idle_next = idle_reg;
        end
        suspend = (idle_next >= suspend_ticks_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_buttons_reg <= '0;
            prev_phase_reg   <= '0;
            primed_reg       <= 1'b0;
            preset_reg       <= mis_pkg::PRESET_RST;
            idle_reg         <= '0;
        end else if (advance) begin
            prev_buttons_reg <= buttons;
            prev_phase_reg   <= phase;
            primed_reg       <= 1'b1;
            preset_reg       <= preset_next;
            idle_reg         <= idle_next;
        end
    end

    // result register
    logic        out_valid_reg;
    logic [71:0] out_data_reg;
    logic        out_report_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_report_reg <= report;
            out_data_reg   <= {4'd0, suspend, changed,
                               mis_pkg::resolution_of(preset_next),
                               mis_pkg::resolution_of(preset_next),
                               preset_next, wheel, dy, dx, buttons};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_report_reg;

    // checks
    a_preset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        preset_reg <= PRESET_TOP)
        else $error("preset index out of range");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed item did not reach result register");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && m_tvalid && !m_tready)
        else $error("input stalled without a pending result");

endmodule
